FILE: rtl/bmpe_pkg.sv
// ----------------------------------------------------------------------------
// bmpe_pkg
// Shared types and constants of the binomial mod-prime engine.
// ----------------------------------------------------------------------------
package bmpe_pkg;

    localparam int VAL_W    = 30;
    localparam int N_W      = 12;
    localparam int M_W      = 13;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int MM_STEPS = PROD_W;
    localparam int MM_CNT_W = $clog2(MM_STEPS + 1);
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [VAL_W-1:0] MODULUS_RESET = 30'd1000000007;
    localparam logic             REG_MODULUS   = 1'b0;

    // mulmod operand pairs
    typedef enum logic [2:0] {
        OP_IDX_ACC = 3'd0,
        OP_ACC_ONE = 3'd1,
        OP_ACC_SQ  = 3'd2,
        OP_SQ_SQ   = 3'd3,
        OP_RD_RD   = 3'd4,
        OP_ACC_INV = 3'd5
    } mm_op_t;

    typedef struct packed {
        logic   load_in;
        logic   acc_one;
        logic   acc_from_mm;
        logic   sq_from_mm;
        logic   exp_load;
        logic   exp_shift;
        logic   idx_clear;
        logic   idx_inc;
        logic   idx_dec;
        logic   mm_start;
        mm_op_t mm_op;
        logic   fact_wr;
        logic   inv_wr;
        logic   rd_q1;
        logic   rd_q2;
        logic   out_load;
        logic   out_zero;
        logic   out_status;
    } dp_cmd_t;

    typedef struct packed {
        logic mm_done;
        logic idx_last;
        logic idx_zero;
        logic exp_zero;
        logic exp_lsb;
        logic q_valid;
        logic is_query;
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: rtl/bmpe_mulmod.sv
// ----------------------------------------------------------------------------
// bmpe_mulmod
// Iterative modular multiplier: one 30x30 product, then restoring reduction
// one product bit per cycle.
// ----------------------------------------------------------------------------
module bmpe_mulmod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bmpe_pkg::VAL_W-1:0] a,
    input  logic [bmpe_pkg::VAL_W-1:0] b,
    input  logic [bmpe_pkg::VAL_W-1:0] md,
    output logic                       done,
    output logic [bmpe_pkg::VAL_W-1:0] res
);
    import bmpe_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [MM_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [VAL_W-1:0]    md_reg;
    logic [VAL_W-1:0]    rem_reg;
    logic [VAL_W:0]      r2;
    logic [VAL_W:0]      r2s;
    logic [VAL_W-1:0]    rem_next;

    assign r2       = {rem_reg, prod_reg[PROD_W-1]};
    assign r2s      = (r2 >= {1'b0, md_reg}) ? r2 - {1'b0, md_reg} : r2;
    assign rem_next = r2s[VAL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MM_CNT_W'(MM_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MM_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= PROD_W'(a) * PROD_W'(b);
            md_reg   <= md;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
            rem_reg  <= rem_next;
        end
    end

    // modulus 0 or 1 reduces everything to zero
    assign done = done_reg;
    assign res  = (md_reg < VAL_W'(2)) ? '0 : rem_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("mulmod restarted while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("mulmod done longer than a cycle");
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && md_reg >= VAL_W'(2)) |-> rem_reg < md_reg)
        else $error("mulmod result not reduced");
`endif
endmodule

FILE: rtl/bmpe_datapath.sv
// ----------------------------------------------------------------------------
// bmpe_datapath
// Factorial and inverse-factorial memories, working registers, the shared
// mulmod unit and the output register.
// ----------------------------------------------------------------------------
module bmpe_datapath #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bmpe_pkg::dp_cmd_t          cmd,
    output bmpe_pkg::dp_stat_t         stat,
    input  logic [bmpe_pkg::VAL_W-1:0] modulus,
    input  logic                       in_cmd,
    input  logic [bmpe_pkg::N_W-1:0]   in_n,
    input  logic [bmpe_pkg::M_W-1:0]   in_m,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bmpe_pkg::VAL_W-1:0] out_value,
    output logic                       out_status
);
    import bmpe_pkg::*;

    localparam int AW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CMPW = 22;

    logic [VAL_W-1:0] fact_mem [TABLE_SIZE];
    logic [VAL_W-1:0] inv_mem  [TABLE_SIZE];

    logic             cmd_reg;
    logic [N_W-1:0]   n_reg;
    logic [M_W-1:0]   m_reg;
    logic [AW-1:0]    idx_reg;
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W-1:0] sq_reg;
    logic [VAL_W-1:0] exp_reg;
    logic [VAL_W-1:0] fact_rd_reg;
    logic [VAL_W-1:0] inv_rd_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic             out_status_reg;

    logic [VAL_W-1:0] one_md;
    logic [VAL_W-1:0] mm_a;
    logic [VAL_W-1:0] mm_b;
    logic [VAL_W-1:0] mm_res;
    logic             mm_done;
    logic [N_W-1:0]   nm_diff;
    logic [AW-1:0]    n_addr;
    logic [AW-1:0]    m_addr;
    logic [AW-1:0]    nm_addr;

    assign one_md  = (modulus >= VAL_W'(2)) ? VAL_W'(1) : '0;
    assign nm_diff = n_reg - m_reg[N_W-1:0];
    assign n_addr  = AW'(n_reg);
    assign m_addr  = AW'(m_reg[N_W-1:0]);
    assign nm_addr = AW'(nm_diff);

    always_comb
    begin
        case (cmd.mm_op)
            OP_IDX_ACC: begin mm_a = VAL_W'(idx_reg); mm_b = acc_reg;    end
            OP_ACC_ONE: begin mm_a = acc_reg;         mm_b = VAL_W'(1);  end
            OP_ACC_SQ:  begin mm_a = acc_reg;         mm_b = sq_reg;     end
            OP_SQ_SQ:   begin mm_a = sq_reg;          mm_b = sq_reg;     end
            OP_RD_RD:   begin mm_a = fact_rd_reg;     mm_b = inv_rd_reg; end
            OP_ACC_INV: begin mm_a = acc_reg;         mm_b = inv_rd_reg; end
            default:    begin mm_a = acc_reg;         mm_b = acc_reg;    end
        endcase
    end

    bmpe_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .md    (modulus),
        .done  (mm_done),
        .res   (mm_res)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= in_cmd;
            n_reg   <= in_n;
            m_reg   <= in_m;
        end
        if (cmd.idx_clear)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
        else if (cmd.idx_dec)
            idx_reg <= idx_reg - 1'b1;
        if (cmd.acc_one)
            acc_reg <= one_md;
        else if (cmd.acc_from_mm)
            acc_reg <= mm_res;
        if (cmd.sq_from_mm)
            sq_reg <= mm_res;
        if (cmd.exp_load)
            exp_reg <= (modulus >= VAL_W'(2)) ? modulus - VAL_W'(2) : '0;
        else if (cmd.exp_shift)
            exp_reg <= exp_reg >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fact_wr)
            fact_mem[idx_reg] <= acc_reg;
        if (cmd.rd_q1)
            fact_rd_reg <= fact_mem[n_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.inv_wr)
            inv_mem[idx_reg] <= acc_reg;
        if (cmd.rd_q1)
            inv_rd_reg <= inv_mem[m_addr];
        else if (cmd.rd_q2)
            inv_rd_reg <= inv_mem[nm_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg  <= cmd.out_zero ? '0 : acc_reg;
            out_status_reg <= cmd.out_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        stat.mm_done  = mm_done;
        stat.idx_last = (idx_reg == AW'(TABLE_SIZE - 1));
        stat.idx_zero = (idx_reg == '0);
        stat.exp_zero = (exp_reg == '0);
        stat.exp_lsb  = exp_reg[0];
        stat.q_valid  = !m_reg[M_W-1] && ({1'b0, n_reg} >= m_reg)
                        && (CMPW'(n_reg) < CMPW'(TABLE_SIZE));
        stat.is_query = cmd_reg;
        stat.out_busy = out_valid_reg && !out_ready;
    end
endmodule

FILE: rtl/bmpe_ctrl.sv
// ----------------------------------------------------------------------------
// bmpe_ctrl
// Sequencer for table build, Fermat inverse and queries.
// ----------------------------------------------------------------------------
module bmpe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output bmpe_pkg::dp_cmd_t  cmd,
    input  bmpe_pkg::dp_stat_t stat
);
    import bmpe_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE      = 19'b0000000000000000001,
        S_B_START   = 19'b0000000000000000010,
        S_B_WR      = 19'b0000000000000000100,
        S_B_MUL     = 19'b0000000000000001000,
        S_B_WAIT    = 19'b0000000000000010000,
        S_P_INIT    = 19'b0000000000000100000,
        S_P_IWAIT   = 19'b0000000000001000000,
        S_P_LOOP    = 19'b0000000000010000000,
        S_P_MWAIT   = 19'b0000000000100000000,
        S_P_SQ      = 19'b0000000001000000000,
        S_P_SWAIT   = 19'b0000000010000000000,
        S_I_WR      = 19'b0000000100000000000,
        S_I_WAIT    = 19'b0000001000000000000,
        S_Q_RD1     = 19'b0000010000000000000,
        S_Q_RD2     = 19'b0000100000000000000,
        S_Q_W1      = 19'b0001000000000000000,
        S_Q_M2      = 19'b0010000000000000000,
        S_Q_W2      = 19'b0100000000000000000,
        S_FIN       = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;
    logic   zero_reg, zero_next;
    logic   stat_reg, stat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
            zero_reg  <= 1'b1;
            stat_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            zero_reg  <= zero_next;
            stat_reg  <= stat_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        zero_next  = zero_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        cmd.mm_op  = OP_IDX_ACC;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_B_START;
                end
            end
            S_B_START:
            begin
                if (stat.is_query)
                begin
                    zero_next = 1'b1;
                    stat_next = !ready_reg;
                    if (ready_reg && stat.q_valid)
                        state_next = S_Q_RD1;
                    else
                        state_next = S_FIN;
                end
                else
                begin
                    cmd.acc_one   = 1'b1;
                    cmd.idx_clear = 1'b1;
                    state_next    = S_B_WR;
                end
            end
            S_B_WR:
            begin
                cmd.fact_wr = 1'b1;
                if (stat.idx_last)
                    state_next = S_P_INIT;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_B_MUL;
                end
            end
            S_B_MUL:
            begin
                cmd.mm_start = 1'b1;
                cmd.mm_op    = OP_IDX_ACC;
                state_next   = S_B_WAIT;
            end
            S_B_WAIT:
            begin
                if (stat.mm_done)
                begin
                    cmd.acc_from_mm = 1'b1;
                    state_next      = S_B_WR;
                end
            end
            // base reduced into sq, exponent p-2, acc starts at one
            S_P_INIT:
            begin
                cmd.mm_start = 1'b1;
                cmd.mm_op    = OP_ACC_ONE;
                cmd.exp_load = 1'b1;
                state_next   = S_P_IWAIT;
            end
            S_P_IWAIT:
            begin
                if (stat.mm_done)
                begin
                    cmd.sq_from_mm = 1'b1;
                    cmd.acc_one    = 1'b1;
                    state_next     = S_P_LOOP;
                end
            end
            S_P_LOOP:
            begin
                if (stat.exp_zero)
                    state_next = S_I_WR;
                else if (stat.exp_lsb)
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = OP_ACC_SQ;
                    state_next   = S_P_MWAIT;
                end
                else
                    state_next = S_P_SQ;
            end
            S_P_MWAIT:
            begin
                if (stat.mm_done)
                begin
                    cmd.acc_from_mm = 1'b1;
                    state_next      = S_P_SQ;
                end
            end
            S_P_SQ:
            begin
                cmd.mm_start = 1'b1;
                cmd.mm_op    = OP_SQ_SQ;
                state_next   = S_P_SWAIT;
            end
            S_P_SWAIT:
            begin
                if (stat.mm_done)
                begin
                    cmd.sq_from_mm = 1'b1;
                    cmd.exp_shift  = 1'b1;
                    state_next     = S_P_LOOP;
                end
            end
            // idx still holds the top entry; walk down
            S_I_WR:
            begin
                cmd.inv_wr = 1'b1;
                if (stat.idx_zero)
                begin
                    ready_next = 1'b1;
                    zero_next  = 1'b1;
                    stat_next  = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_op    = OP_IDX_ACC;
                    state_next   = S_I_WAIT;
                end
            end
            S_I_WAIT:
            begin
                if (stat.mm_done)
                begin
                    cmd.acc_from_mm = 1'b1;
                    cmd.idx_dec     = 1'b1;
                    state_next      = S_I_WR;
                end
            end
            S_Q_RD1:
            begin
                cmd.rd_q1  = 1'b1;
                state_next = S_Q_RD2;
            end
            S_Q_RD2:
            begin
                cmd.rd_q2    = 1'b1;
                cmd.mm_start = 1'b1;
                cmd.mm_op    = OP_RD_RD;
                state_next   = S_Q_W1;
            end
            S_Q_W1:
            begin
                if (stat.mm_done)
                begin
                    cmd.acc_from_mm = 1'b1;
                    state_next      = S_Q_M2;
                end
            end
            S_Q_M2:
            begin
                cmd.mm_start = 1'b1;
                cmd.mm_op    = OP_ACC_INV;
                state_next   = S_Q_W2;
            end
            S_Q_W2:
            begin
                if (stat.mm_done)
                begin
                    cmd.acc_from_mm = 1'b1;
                    zero_next       = 1'b0;
                    stat_next       = 1'b0;
                    state_next      = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_zero   = zero_reg;
                    cmd.out_status = stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/binomial_mod_prime_engine.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime_engine
// Binomial coefficients mod a prime from factorial / inverse-factorial tables.
//
//   channel   signals                          carries
//   s_*       tvalid tready tdata tuser        command: build or query (n, m)
//   m_*       tvalid tready tdata tuser        result: value, status
//   apb       psel penable pwrite paddr ...    modulus register at 0x0
//
// Each mulmod is one product followed by 60 reduction steps, and a query
// chains two mulmods. A build takes about 2*TABLE_SIZE mulmods plus
// up to 61 for the exponentiation. One item is worked on at a time; the next
// is taken while a result waits in the output register. Reset clears the
// ready flag but not the tables; they hold nothing usable until a build.
// ----------------------------------------------------------------------------
module binomial_mod_prime_engine #(
    parameter int TABLE_SIZE = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // n[11:0], m[24:12]
    input  logic [0:0]                   s_tuser,   // cmd
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // value[29:0]
    output logic [0:0]                   m_tuser,   // status
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bmpe_pkg::PADDR_W-1:0] paddr,
    input  logic [bmpe_pkg::PDATA_W-1:0] pwdata,
    output logic [bmpe_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import bmpe_pkg::*;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [VAL_W-1:0] modulus_reg;
    logic [VAL_W-1:0] out_value;
    logic             out_status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= MODULUS_RESET;
        else if (psel && penable && pwrite && (paddr[2] == REG_MODULUS))
            modulus_reg <= pwdata[VAL_W-1:0];
    end

    assign prdata = (paddr[2] == REG_MODULUS) ? PDATA_W'(modulus_reg) : '0;

    bmpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bmpe_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .modulus    (modulus_reg),
        .in_cmd     (s_tuser[0]),
        .in_n       (s_tdata[N_W-1:0]),
        .in_m       (s_tdata[N_W+M_W-1:N_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_status (out_status)
    );

    assign m_tdata = {2'b00, out_value};
    assign m_tuser = out_status;
endmodule

FILE: bench/binomial_mod_prime_engine_check.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime_engine_check
// Watches the command, result and register channels. It keeps its own copy
// of the factorial tables and the modulus, predicts each result and compares.
// ----------------------------------------------------------------------------
module binomial_mod_prime_engine_check (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [31:0]                   m_tdata,
    input  logic [0:0]                    m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpe_pkg::PADDR_W-1:0]  paddr,
    input  logic [bmpe_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bmpe_pkg::*;

    localparam int TBL = 4096;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             status;
    } coef_t;

    logic [VAL_W-1:0] fact_tbl [TBL];
    logic [VAL_W-1:0] inv_fact_tbl [TBL];
    logic             tbl_built;
    logic [VAL_W-1:0] cur_mod;
    coef_t            coef_q [$];

    function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                                longint unsigned md);
        if (md < 2)
            return 0;
        return ((a % md) * (b % md)) % md;
    endfunction

    function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned ex,
                                                longint unsigned md);
        longint unsigned acc;
        longint unsigned sq;
        acc = mod_mul(1, 1, md);
        sq  = mod_mul(base, 1, md);
        while (ex > 0) begin
            if (ex[0])
                acc = mod_mul(acc, sq, md);
            sq = mod_mul(sq, sq, md);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    task automatic build_factorials();
        longint unsigned md;
        md = cur_mod;
        fact_tbl[0] = VAL_W'(mod_mul(1, 1, md));
        for (int i = 1; i < TBL; i++)
            fact_tbl[i] = VAL_W'(mod_mul(i, fact_tbl[i-1], md));
        inv_fact_tbl[TBL-1] = VAL_W'(mod_pow(fact_tbl[TBL-1], (md >= 2) ? md - 2 : 0, md));
        for (int i = TBL - 1; i > 0; i--)
            inv_fact_tbl[i-1] = VAL_W'(mod_mul(inv_fact_tbl[i], i, md));
        tbl_built = 1'b1;
    endtask

    function automatic coef_t predict_coef(logic cmd, logic [N_W-1:0] n,
                                           logic signed [M_W-1:0] m);
        coef_t r;
        longint unsigned v;
        r = '0;
        if (cmd == 1'b1) begin
            if (!tbl_built)
                r.status = 1'b1;
            else if (m >= 0 && int'(m) <= int'(n)) begin
                v = mod_mul(fact_tbl[n], inv_fact_tbl[m], cur_mod);
                v = mod_mul(v, inv_fact_tbl[int'(n) - int'(m)], cur_mod);
                r.value = VAL_W'(v);
            end
        end
        return r;
    endfunction

    assign pending = coef_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        coef_t exp_c;
        if (!rst_n) begin
            tbl_built  = 1'b0;
            cur_mod    = MODULUS_RESET;
            fail_count = 0;
            coef_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == {PADDR_W{1'b0}})
                cur_mod = pwdata[VAL_W-1:0];
            if (m_tvalid && m_tready) begin
                if (coef_q.size() == 0) begin
                    $error("unexpected result transfer: value %0d status %0d",
                           m_tdata[VAL_W-1:0], m_tuser[0]);
                    fail_count++;
                end else begin
                    exp_c = coef_q.pop_front();
                    if (m_tdata[VAL_W-1:0] !== exp_c.value) begin
                        $error("value: expected %0d, got %0d", exp_c.value,
                               m_tdata[VAL_W-1:0]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== exp_c.status) begin
                        $error("status: expected %0d, got %0d", exp_c.status, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                // the build result is zero; tables update after predicting it
                coef_q.push_back(predict_coef(s_tuser[0], s_tdata[11:0], s_tdata[24:12]));
                if (s_tuser[0] == 1'b0)
                    build_factorials();
            end
        end
    end

endmodule

FILE: bench/binomial_mod_prime_engine_test.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime_engine_test
// Drives builds and binomial queries under several modulus settings, with
// random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module binomial_mod_prime_engine_test;
    timeunit 1ns;
    timeprecision 1ps;
    import bmpe_pkg::*;

    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [31:0]        s_tdata;    // n[11:0], m[24:12]
    logic [0:0]         s_tuser;    // cmd
    logic               m_tvalid;
    logic               m_tready;
    logic [31:0]        m_tdata;    // value[29:0]
    logic [0:0]         m_tuser;    // status
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    logic               quiet;
    logic               hold_req;
    int                 n_items;
    int                 n_mods;

    binomial_mod_prime_engine u_dut (.*);

    binomial_mod_prime_engine_check u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("binomial_mod_prime_engine: mismatch");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic send_cmd(logic cmd, logic [N_W-1:0] n, logic [M_W-1:0] m);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, m, n};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_modulus(logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_mods++;
    endtask

    task automatic random_queries(int count);
        logic [N_W-1:0] n;
        logic [M_W-1:0] m;
        for (int i = 0; i < count; i++) begin
            n = N_W'($urandom_range(0, 4095));
            if ($urandom_range(0, 9) < 8)
                m = M_W'($urandom_range(0, n));
            else
                m = M_W'($urandom_range(0, 8191));
            send_cmd(CMD_QUERY, n, m);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        n_items  = 0;
        n_mods   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries before any build report the status flag
        send_cmd(CMD_QUERY, 12'd5, 13'd2);
        send_cmd(CMD_QUERY, 12'd4095, 13'h1FFF);
        drain();
        write_modulus(32'd1000000007);
        send_cmd(CMD_BUILD, 12'hFFF, 13'h1FFF);

        send_cmd(CMD_QUERY, 12'd0, 13'd0);
        send_cmd(CMD_QUERY, 12'd4095, 13'd0);
        send_cmd(CMD_QUERY, 12'd4095, 13'd4095);
        send_cmd(CMD_QUERY, 12'd4095, 13'd2048);
        send_cmd(CMD_QUERY, 12'd4095, 13'd1);
        send_cmd(CMD_QUERY, 12'd1, 13'd1);
        send_cmd(CMD_QUERY, 12'd10, 13'd11);
        send_cmd(CMD_QUERY, 12'd4094, 13'd4095);
        send_cmd(CMD_QUERY, 12'd100, 13'h1000);   // most negative m
        send_cmd(CMD_QUERY, 12'd100, 13'h1FFF);   // m = -1
        send_cmd(CMD_QUERY, 12'd2730, 13'd1365);

        // long stall on the result side while commands keep coming
        hold_req = 1'b1;
        random_queries(30);
        random_queries(120);
        drain();

        // tables kept, modulus changed to its largest value and then to 2
        write_modulus(32'd1073741823);
        random_queries(100);
        drain();
        write_modulus(32'd2);
        random_queries(60);
        drain();

        // rebuild under a small prime just above the table size
        write_modulus(32'd4099);
        send_cmd(CMD_BUILD, 12'd0, 13'd0);
        random_queries(150);
        drain();

        write_modulus(32'd1000000007);
        quiet = 1'b1;
        random_queries(170);
        drain();
        repeat (300) @(posedge clk);

        $display("ran %0d commands (2 builds) across %0d modulus writes", n_items, n_mods);
        $display("covered unbuilt, out-of-range, negative and extreme-index queries");
        if (fail_count == 0)
            $display("binomial_mod_prime_engine: match");
        else
            $display("binomial_mod_prime_engine: mismatch");
        $finish;
    end

endmodule
